>>> hw/rtl/histogram_color_quantizer_defines.svh
// assertion macros for the histogram color quantizer
`ifndef HISTOGRAM_COLOR_QUANTIZER_DEFINES_SVH
`define HISTOGRAM_COLOR_QUANTIZER_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define HCQ_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define HCQ_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

>>> hw/rtl/hcq_pkg.sv
// shared types and constants of the histogram color quantizer
`timescale 1ns / 1ps
package hcq_pkg;

  // fixed sizes
  localparam int BINS            = 256;
  localparam int PIX_W           = 25;
  localparam int LEV_W           = 5;
  localparam int DEF_MAX_LEVELS  = 16;
  localparam int DEF_CHANNELS    = 3;
  localparam int DEF_COUNT_WIDTH = 24;

  // op codes
  localparam logic [1:0] OP_ACC   = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_MAP   = 2'd2;

  // register indexes
  localparam logic [1:0] REG_PIXELS = 2'd0;
  localparam logic [1:0] REG_RED    = 2'd1;
  localparam logic [1:0] REG_GREEN  = 2'd2;
  localparam logic [1:0] REG_BLUE   = 2'd3;

  // reset values of the registers
  localparam logic [PIX_W-1:0] RST_PIXELS = 25'd1;
  localparam logic [LEV_W-1:0] RST_RED    = 5'd8;
  localparam logic [LEV_W-1:0] RST_GREEN  = 5'd8;
  localparam logic [LEV_W-1:0] RST_BLUE   = 5'd4;

  localparam logic [7:0] TOP_VALUE = 8'd255;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] channel;
    logic [7:0] pixel_value;
  } item_t;

  typedef struct packed {
    logic [7:0] mapped_value;
    logic [1:0] channel_out;
  } result_t;

endpackage

>>> hw/rtl/histogram_color_quantizer.sv
// top level of the histogram color quantizer
// Command interface: an item word on item is taken when start is high and
// busy is low. Op 0 counts the pixel into its channel's histogram. Op 1
// divides image_pixels by the level count in the shift divider, then walks
// the 256 bins at one bin per cycle through the histogram memory read port,
// clearing each bin, writes the level and boundary tables, and finally
// writes 255 as the last boundary. Op 2 scans the channel's tables, reading
// and then comparing each entry through the table memory read port; its
// result word is then shown on result, with result_strobe high for one
// cycle. The receiver has no back pressure and must take the word in that
// cycle. Ops 0 and 1, op 3 and items of an unknown channel give no result.
// Configuration words on the cfg channel are always taken (cfg_ready is
// tied high) and must only come while the block is idle.
// After reset the block runs a clearing pass over the histogram memory, all
// CHANNELS*256 bins (768 by default), clearing the tables alongside; busy
// stays high until it ends.
`timescale 1ns / 1ps
`include "histogram_color_quantizer_defines.svh"
module histogram_color_quantizer #(
  parameter int MAX_LEVELS  = hcq_pkg::DEF_MAX_LEVELS,
  parameter int CHANNELS    = hcq_pkg::DEF_CHANNELS,
  parameter int COUNT_WIDTH = hcq_pkg::DEF_COUNT_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  hcq_pkg::item_t                item,
  output logic                          result_strobe,
  output hcq_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [hcq_pkg::PIX_W-1:0]     cfg_data
);

  localparam int LW     = $clog2(MAX_LEVELS);
  localparam int NW     = $clog2(MAX_LEVELS + 1);
  localparam int HDEPTH = CHANNELS * hcq_pkg::BINS;
  localparam int HA_W   = $clog2(HDEPTH);
  localparam int TDEPTH = CHANNELS * MAX_LEVELS;
  localparam int TA_W   = $clog2(TDEPTH);
  localparam int ACC_W  = (COUNT_WIDTH > hcq_pkg::PIX_W ? COUNT_WIDTH : hcq_pkg::PIX_W) + 10;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_ACC_R = 4'd2;
  localparam logic [3:0] S_ACC_W = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_BLD   = 4'd5;
  localparam logic [3:0] S_BEND  = 4'd6;
  localparam logic [3:0] S_MAP_R = 4'd7;
  localparam logic [3:0] S_MAP_C = 4'd8;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // registers
  logic [3:0]                  state;
  logic [hcq_pkg::PIX_W-1:0]   image_pixels;
  logic [hcq_pkg::LEV_W-1:0]   levels_red, levels_green, levels_blue;
  logic [1:0]                  cur_op, cur_ch;
  logic [7:0]                  cur_px;
  logic [NW-1:0]               n_eff;
  logic [HA_W-1:0]             clr;
  logic [8:0]                  vcnt;
  logic [NW-1:0]               idx;
  logic [LW-1:0]               li, bi;
  logic [ACC_W-1:0]            total, edge_pt, step;
  logic signed [ACC_W:0]       run, half;
  logic [7:0]                  held;

  // memory ports
  logic [HA_W-1:0]        h_rd_addr, h_wr_addr;
  logic [COUNT_WIDTH-1:0] h_rd_data, h_wr_data;
  logic                   h_wr_en;
  logic [TA_W-1:0]        t_rd_addr, l_wr_addr, b_wr_addr;
  logic [7:0]             l_rd_data, b_rd_data, l_wr_data, b_wr_data;
  logic                   l_wr_en, b_wr_en;

  // divider
  logic                     div_start, div_done;
  logic [hcq_pkg::PIX_W-1:0] div_q;

  // build step values
  logic [ACC_W-1:0]      total_next;
  logic signed [ACC_W:0] run_next;
  logic                  lvl_hit, bnd_hit;
  logic [7:0]            pv;

  logic accept;
  logic ch_ok;
  logic [NW-1:0] n_in;

  // effective level count of a channel
  function automatic logic [NW-1:0] eff_levels(input logic [1:0] ch,
                                               input logic [hcq_pkg::LEV_W-1:0] r,
                                               input logic [hcq_pkg::LEV_W-1:0] g,
                                               input logic [hcq_pkg::LEV_W-1:0] b);
    logic [hcq_pkg::LEV_W-1:0] lv;
    case (ch)
      2'd0:    lv = r;
      2'd1:    lv = g;
      2'd2:    lv = b;
      default: lv = hcq_pkg::LEV_W'(1);
    endcase
    if (lv == '0) begin
      lv = hcq_pkg::LEV_W'(1);
    end
    if (int'(lv) > MAX_LEVELS) begin
      return NW'(MAX_LEVELS);
    end
    return NW'(lv);
  endfunction

  assign busy      = state != S_IDLE;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign ch_ok     = int'(item.channel) < CHANNELS;
  assign n_in      = eff_levels(item.channel, levels_red, levels_green, levels_blue);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_pixels <= hcq_pkg::RST_PIXELS;
      levels_red   <= hcq_pkg::RST_RED;
      levels_green <= hcq_pkg::RST_GREEN;
      levels_blue  <= hcq_pkg::RST_BLUE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hcq_pkg::REG_PIXELS: image_pixels <= cfg_data;
        hcq_pkg::REG_RED:    levels_red   <= cfg_data[hcq_pkg::LEV_W-1:0];
        hcq_pkg::REG_GREEN:  levels_green <= cfg_data[hcq_pkg::LEV_W-1:0];
        hcq_pkg::REG_BLUE:   levels_blue  <= cfg_data[hcq_pkg::LEV_W-1:0];
        default: ;
      endcase
    end
  end

  // build step: running sums and slice tests
  assign pv         = vcnt[7:0] - 8'd1;
  assign total_next = total + ACC_W'(h_rd_data);
  assign run_next   = run + (ACC_W + 1)'(h_rd_data);
  assign lvl_hit    = run_next >= half;
  assign bnd_hit    = total_next > edge_pt;

  assign div_start = accept && ch_ok && item.op == hcq_pkg::OP_BUILD;

  // memory addressing
  always_comb begin
    h_rd_addr = HA_W'(cur_ch) * HA_W'(hcq_pkg::BINS) + HA_W'(vcnt[7:0]);
    h_wr_addr = HA_W'(cur_ch) * HA_W'(hcq_pkg::BINS) + HA_W'(pv);
    h_wr_data = '0;
    h_wr_en   = 1'b0;
    t_rd_addr = TA_W'(cur_ch) * TA_W'(MAX_LEVELS) + TA_W'(idx[LW-1:0]);
    l_wr_addr = TA_W'(cur_ch) * TA_W'(MAX_LEVELS) + TA_W'(li);
    b_wr_addr = TA_W'(cur_ch) * TA_W'(MAX_LEVELS) + TA_W'(bi);
    l_wr_data = pv;
    b_wr_data = pv;
    l_wr_en   = 1'b0;
    b_wr_en   = 1'b0;
    if (accept) begin
      h_rd_addr = HA_W'(item.channel) * HA_W'(hcq_pkg::BINS) + HA_W'(item.pixel_value);
    end
    unique case (state)
      S_CLEAR: begin
        h_wr_addr = clr;
        h_wr_en   = 1'b1;
        l_wr_addr = TA_W'(clr);
        b_wr_addr = TA_W'(clr);
        l_wr_data = '0;
        b_wr_data = '0;
        l_wr_en   = int'(clr) < TDEPTH;
        b_wr_en   = int'(clr) < TDEPTH;
      end
      // hold the bin address so the count is valid in the write cycle
      S_ACC_R: begin
        h_rd_addr = HA_W'(cur_ch) * HA_W'(hcq_pkg::BINS) + HA_W'(cur_px);
      end
      S_ACC_W: begin
        h_wr_addr = HA_W'(cur_ch) * HA_W'(hcq_pkg::BINS) + HA_W'(cur_px);
        h_wr_data = (h_rd_data == COUNT_MAX) ? h_rd_data : h_rd_data + 1'b1;
        h_wr_en   = 1'b1;
      end
      S_BLD: begin
        h_wr_en = vcnt != '0;
        l_wr_en = vcnt != '0 && lvl_hit;
        b_wr_en = vcnt != '0 && bnd_hit;
      end
      S_BEND: begin
        b_wr_data = hcq_pkg::TOP_VALUE;
        b_wr_en   = 1'b1;
      end
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr           <= '0;
      held          <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && ch_ok) begin
            case (item.op)
              hcq_pkg::OP_ACC:   state <= S_ACC_R;
              hcq_pkg::OP_BUILD: state <= S_DIV;
              hcq_pkg::OP_MAP:   state <= S_MAP_R;
              default:           state <= S_IDLE;
            endcase
          end
        end
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (int'(clr) == HDEPTH - 1) begin
            state <= S_IDLE;
          end
        end
        S_ACC_R: state <= S_ACC_W;
        S_ACC_W: state <= S_IDLE;
        S_DIV: begin
          if (div_done) begin
            state <= S_BLD;
          end
        end
        S_BLD: begin
          if (vcnt == 9'd256) begin
            state <= S_BEND;
          end
        end
        S_BEND:  state <= S_IDLE;
        S_MAP_R: state <= S_MAP_C;
        S_MAP_C: begin
          if (cur_px <= b_rd_data) begin
            held          <= l_rd_data;
            result_strobe <= 1'b1;
            state         <= S_IDLE;
          end else if (idx == n_eff - 1'b1) begin
            result_strobe <= 1'b1;
            state         <= S_IDLE;
          end else begin
            state <= S_MAP_R;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op <= item.op;
      cur_ch <= item.channel;
      cur_px <= item.pixel_value;
      n_eff  <= n_in;
      idx    <= '0;
    end
    if (state == S_DIV && div_done) begin
      step    <= ACC_W'(div_q);
      half    <= (ACC_W + 1)'(div_q >> 1);
      edge_pt <= ACC_W'(div_q);
      total   <= '0;
      run     <= '0;
      li      <= '0;
      bi      <= '0;
      vcnt    <= '0;
    end
    if (state == S_BLD) begin
      vcnt <= vcnt + 1'b1;
      if (vcnt != '0) begin
        total <= total_next;
        if (lvl_hit) begin
          run <= -half;
          if (int'(li) < MAX_LEVELS - 1) begin
            li <= li + 1'b1;
          end
        end else begin
          run <= run_next;
        end
        if (bnd_hit) begin
          edge_pt <= edge_pt + step;
          if (int'(bi) < MAX_LEVELS - 1) begin
            bi <= bi + 1'b1;
          end
        end
      end
    end
    if (state == S_MAP_C) begin
      idx <= idx + 1'b1;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (state == S_MAP_C) begin
      result.mapped_value <= (cur_px <= b_rd_data) ? l_rd_data : held;
      result.channel_out  <= cur_ch;
    end
  end

  hcq_hist_mem #(
    .DEPTH (HDEPTH),
    .AW    (HA_W),
    .DW    (COUNT_WIDTH)
  ) u_hist (
    .clk     (clk),
    .rd_addr (h_rd_addr),
    .rd_data (h_rd_data),
    .wr_en   (h_wr_en),
    .wr_addr (h_wr_addr),
    .wr_data (h_wr_data)
  );

  hcq_table_mem #(
    .DEPTH (TDEPTH),
    .AW    (TA_W)
  ) u_levels (
    .clk     (clk),
    .rd_addr (t_rd_addr),
    .rd_data (l_rd_data),
    .wr_en   (l_wr_en),
    .wr_addr (l_wr_addr),
    .wr_data (l_wr_data)
  );

  hcq_table_mem #(
    .DEPTH (TDEPTH),
    .AW    (TA_W)
  ) u_bounds (
    .clk     (clk),
    .rd_addr (t_rd_addr),
    .rd_data (b_rd_data),
    .wr_en   (b_wr_en),
    .wr_addr (b_wr_addr),
    .wr_data (b_wr_data)
  );

  hcq_divider #(
    .DW (hcq_pkg::PIX_W),
    .VW (NW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (image_pixels),
    .divisor  (n_in),
    .done     (div_done),
    .quotient (div_q)
  );

  // checks
  `HCQ_ASSERT_NOW(a_no_result_after_accept, result_strobe, !$past(accept), "result right after accept")
  `HCQ_ASSERT_NEXT(a_single_result, result_strobe, !result_strobe, "back to back results")
  `HCQ_ASSERT_NOW(a_map_only_result, result_strobe, cur_op == hcq_pkg::OP_MAP, "result from non map op")
  `HCQ_ASSERT_NOW(a_div_nonzero, state == S_DIV, n_eff != '0, "zero level count in divide")

endmodule

>>> hw/rtl/hcq_hist_mem.sv
// histogram bin memory, one write and one registered read port
`timescale 1ns / 1ps
module hcq_hist_mem #(
  parameter int DEPTH = 768,
  parameter int AW    = 10,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/hcq_table_mem.sv
// level or boundary table memory, one write and one registered read port
`timescale 1ns / 1ps
module hcq_table_mem #(
  parameter int DEPTH = 48,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/hcq_divider.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module hcq_divider #(
  parameter int DW = 25,
  parameter int VW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [DW-1:0] quo;
  logic [VW:0]   shifted;
  logic          fits;

  // trial subtract of the shifted partial remainder
  assign shifted = {rem, quo[DW-1]};
  assign fits    = shifted >= {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(DW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (cnt != '0) begin
      quo <= {quo[DW-2:0], fits};
      rem <= fits ? VW'(shifted - {1'b0, dvs}) : shifted[VW-1:0];
    end
  end

  assign quotient = quo;

endmodule

>>> verif/tb_top.sv
// self-checking testbench for the histogram color quantizer
`timescale 1ns / 1ps
module tb_top;

  localparam int NLEV = hcq_pkg::DEF_MAX_LEVELS;
  localparam int NCH  = hcq_pkg::DEF_CHANNELS;
  localparam logic [hcq_pkg::DEF_COUNT_WIDTH-1:0] COUNT_FULL = '1;

  typedef struct {
    hcq_pkg::item_t   it;
    bit               typed;
    hcq_pkg::result_t res;
  } row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  hcq_pkg::item_t            item = '0;
  logic                      cfg_valid = 1'b0;
  logic [1:0]                cfg_index = hcq_pkg::REG_PIXELS;
  logic [hcq_pkg::PIX_W-1:0] cfg_data = '0;
  logic                      busy;
  logic                      result_strobe;
  hcq_pkg::result_t          result;
  logic                      cfg_ready;

  histogram_color_quantizer uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_strobe(result_strobe), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the quantizer state
  logic [hcq_pkg::DEF_COUNT_WIDTH-1:0] hist_bins [NCH][hcq_pkg::BINS];
  logic [7:0]                          level_tab [NCH][NLEV];
  logic [7:0]                          bound_tab [NCH][NLEV];
  logic [7:0]                          held_level;
  logic [hcq_pkg::PIX_W-1:0]           img_pixels;
  logic [hcq_pkg::LEV_W-1:0]           level_cfg [NCH];

  hcq_pkg::result_t mapped_pending [$];
  hcq_pkg::result_t want;
  int               errors;
  int               items_sent;
  bit               burst;

  function automatic int eff_levels(int ch);
    int n;
    n = int'(level_cfg[ch]);
    if (n == 0) n = 1;
    if (n > NLEV) n = NLEV;
    return n;
  endfunction

  // one pass over the bins: levels at slice middles, boundaries at slice edges
  task automatic build_palette(int ch);
    longint half, step, edge_pt, total, run;
    int n, li, bi;
    n = eff_levels(ch);
    half = longint'(img_pixels) / (2 * n);
    step = longint'(img_pixels) / n;
    edge_pt = step;
    total = 0;
    run = 0;
    li = 0;
    bi = 0;
    for (int v = 0; v < hcq_pkg::BINS; v++) begin
      total += hist_bins[ch][v];
      run += hist_bins[ch][v];
      hist_bins[ch][v] = '0;
      if (run >= half) begin
        level_tab[ch][li] = v[7:0];
        if (li < NLEV - 1) li++;
        run = -half;
      end
      if (total > edge_pt) begin
        bound_tab[ch][bi] = v[7:0];
        if (bi < NLEV - 1) bi++;
        edge_pt += step;
      end
    end
    bound_tab[ch][bi] = hcq_pkg::TOP_VALUE;
  endtask

  task automatic quantize_item(hcq_pkg::item_t it, output bit has,
                               output hcq_pkg::result_t r);
    int ch, n;
    has = 1'b0;
    r = '0;
    ch = int'(it.channel);
    if (ch >= NCH) return;
    case (it.op)
      hcq_pkg::OP_ACC: begin
        if (hist_bins[ch][it.pixel_value] != COUNT_FULL)
          hist_bins[ch][it.pixel_value]++;
      end
      hcq_pkg::OP_BUILD: build_palette(ch);
      hcq_pkg::OP_MAP: begin
        n = eff_levels(ch);
        for (int i = 0; i < n; i++) begin
          if (it.pixel_value <= bound_tab[ch][i]) begin
            held_level = level_tab[ch][i];
            break;
          end
        end
        r.mapped_value = held_level;
        r.channel_out = it.channel;
        has = 1'b1;
      end
      default: ;
    endcase
  endtask

  // compare each result word with the oldest pending one
  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (mapped_pending.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %0d/%0d",
                 $time, result.mapped_value, result.channel_out);
        errors++;
      end else begin
        want = mapped_pending.pop_front();
        if (result.mapped_value !== want.mapped_value) begin
          $display("%0t mapped_value: expected %0d, actual %0d",
                   $time, want.mapped_value, result.mapped_value);
          errors++;
        end
        if (result.channel_out !== want.channel_out) begin
          $display("%0t channel_out: expected %0d, actual %0d",
                   $time, want.channel_out, result.channel_out);
          errors++;
        end
      end
    end
  end

  function automatic int draw_gap();
    return burst ? 0 : int'($urandom_range(0, 12));
  endfunction

  // drive one item word and wait until it is taken
  task automatic send_item(hcq_pkg::item_t it, int gap, bit typed = 1'b0,
                           hcq_pkg::result_t typed_res = '0);
    bit has;
    hcq_pkg::result_t r;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    quantize_item(it, has, r);
    if (has) mapped_pending.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  // drain pending results, then cover a table build still running
  task automatic settle();
    start <= 1'b0;
    while (mapped_pending.size() != 0) @(posedge clk);
    repeat (320) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [hcq_pkg::PIX_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      hcq_pkg::REG_PIXELS: img_pixels = data;
      hcq_pkg::REG_RED:    level_cfg[0] = data[hcq_pkg::LEV_W-1:0];
      hcq_pkg::REG_GREEN:  level_cfg[1] = data[hcq_pkg::LEV_W-1:0];
      hcq_pkg::REG_BLUE:   level_cfg[2] = data[hcq_pkg::LEV_W-1:0];
      default: ;
    endcase
  endtask

  function automatic hcq_pkg::item_t mk_item(logic [1:0] op, logic [1:0] ch, logic [7:0] px);
    hcq_pkg::item_t it;
    it.op = op;
    it.channel = ch;
    it.pixel_value = px;
    return it;
  endfunction

  // one configuration followed by accumulate, build and map traffic
  task automatic run_phase(logic [hcq_pkg::PIX_W-1:0] pix, logic [4:0] lr, logic [4:0] lg,
                           logic [4:0] lb);
    int cnt, center, spread, p;
    settle();
    write_reg(hcq_pkg::REG_PIXELS, pix);
    write_reg(hcq_pkg::REG_RED, hcq_pkg::PIX_W'(lr));
    write_reg(hcq_pkg::REG_GREEN, hcq_pkg::PIX_W'(lg));
    write_reg(hcq_pkg::REG_BLUE, hcq_pkg::PIX_W'(lb));
    cfg_valid <= 1'b0;
    burst = ($urandom_range(0, 3) == 0);
    for (int ch = 0; ch < NCH; ch++) begin
      cnt = (pix <= 64) ? int'(pix) + int'($urandom_range(0, 4)) - 2
                        : int'($urandom_range(10, 60));
      center = int'($urandom_range(0, 255));
      spread = int'($urandom_range(0, 128));
      for (int k = 0; k < cnt; k++) begin
        p = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (p < 0) p = 0;
        if (p > 255) p = 255;
        if ($urandom_range(0, 14) == 0)
          send_item(mk_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                            8'($urandom_range(0, 255))),
                    draw_gap());
        send_item(mk_item(hcq_pkg::OP_ACC, 2'(ch), 8'(p)), draw_gap());
      end
    end
    // occasionally leave a channel unbuilt so its old tables stay in use
    for (int ch = 0; ch < NCH; ch++)
      if ($urandom_range(0, 5) != 0)
        send_item(mk_item(hcq_pkg::OP_BUILD, 2'(ch), 8'($urandom_range(0, 255))),
                  draw_gap());
    for (int k = 0; k < 14; k++)
      send_item(mk_item(hcq_pkg::OP_MAP, 2'($urandom_range(0, 2)), 8'($urandom_range(0, 255))),
                draw_gap());
  endtask

  function automatic row_t mk_row(logic [1:0] op, logic [1:0] ch, logic [7:0] px,
                                  bit typed = 1'b0, logic [7:0] mv = '0);
    row_t r;
    r.it = mk_item(op, ch, px);
    r.typed = typed;
    r.res.mapped_value = mv;
    r.res.channel_out = ch;
    return r;
  endfunction

  initial begin
    row_t dir_rows [$];
    for (int c = 0; c < NCH; c++) begin
      for (int v = 0; v < hcq_pkg::BINS; v++) hist_bins[c][v] = '0;
      for (int i = 0; i < NLEV; i++) begin
        level_tab[c][i] = '0;
        bound_tab[c][i] = '0;
      end
    end
    held_level = '0;
    img_pixels = hcq_pkg::RST_PIXELS;
    level_cfg[0] = hcq_pkg::RST_RED;
    level_cfg[1] = hcq_pkg::RST_GREEN;
    level_cfg[2] = hcq_pkg::RST_BLUE;
    errors = 0;
    items_sent = 0;
    burst = 1'b0;

    // fresh tables after reset, unknown op and channel, then a first build
    dir_rows.push_back(mk_row(hcq_pkg::OP_MAP, 2'd0, 8'd0, 1'b1, 8'd0));
    dir_rows.push_back(mk_row(hcq_pkg::OP_MAP, 2'd2, 8'd255, 1'b1, 8'd0));
    dir_rows.push_back(mk_row(2'd3, 2'd0, 8'd17));
    dir_rows.push_back(mk_row(hcq_pkg::OP_ACC, 2'd3, 8'd40));
    dir_rows.push_back(mk_row(hcq_pkg::OP_MAP, 2'd3, 8'd40));
    dir_rows.push_back(mk_row(hcq_pkg::OP_BUILD, 2'd3, 8'd0));
    dir_rows.push_back(mk_row(hcq_pkg::OP_ACC, 2'd0, 8'd0));
    dir_rows.push_back(mk_row(hcq_pkg::OP_ACC, 2'd0, 8'd255));
    dir_rows.push_back(mk_row(hcq_pkg::OP_ACC, 2'd1, 8'd128));
    dir_rows.push_back(mk_row(hcq_pkg::OP_ACC, 2'd1, 8'd127));
    dir_rows.push_back(mk_row(hcq_pkg::OP_BUILD, 2'd0, 8'd0));
    dir_rows.push_back(mk_row(hcq_pkg::OP_BUILD, 2'd1, 8'd255));
    dir_rows.push_back(mk_row(hcq_pkg::OP_MAP, 2'd0, 8'd0));
    dir_rows.push_back(mk_row(hcq_pkg::OP_MAP, 2'd0, 8'd255));
    dir_rows.push_back(mk_row(hcq_pkg::OP_MAP, 2'd0, 8'd128));
    dir_rows.push_back(mk_row(hcq_pkg::OP_MAP, 2'd1, 8'd128));
    dir_rows.push_back(mk_row(hcq_pkg::OP_MAP, 2'd1, 8'd1));
    dir_rows.push_back(mk_row(hcq_pkg::OP_BUILD, 2'd2, 8'd85));
    dir_rows.push_back(mk_row(hcq_pkg::OP_MAP, 2'd2, 8'd7));
    dir_rows.push_back(mk_row(hcq_pkg::OP_MAP, 2'd2, 8'd255));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_item(dir_rows[i].it, int'($urandom_range(0, 12)), dir_rows[i].typed,
                dir_rows[i].res);

    // register extremes: images of 2^24 pixels and of one pixel, level counts of zero and above the table size
    run_phase(25'h1000000, 5'd16, 5'd0, 5'd31);
    run_phase(25'd1, 5'd1, 5'd16, 5'd31);
    while (items_sent < 410) begin
      run_phase(($urandom_range(0, 7) == 0) ? hcq_pkg::PIX_W'($urandom_range(0, 25'h1FFFFFF))
                                             : hcq_pkg::PIX_W'($urandom_range(0, 40)),
                ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(1, 16)),
                ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(1, 16)),
                ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(1, 16)));
    end

    settle();
    if (errors == 0) begin
      $display("** histogram_color_quantizer: PASSED **");
    end else begin
      $display("** histogram_color_quantizer: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("** histogram_color_quantizer: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/hcq_pkg.sv
hw/rtl/hcq_hist_mem.sv
hw/rtl/hcq_table_mem.sv
hw/rtl/hcq_divider.sv
hw/rtl/histogram_color_quantizer.sv
verif/tb_top.sv
